// ===== src/bmmd_pkg.sv =====
`timescale 1ns / 1ps

package bmmd_pkg;

  // result target codes
  typedef enum logic [2:0] {
    TGT_INTERNAL = 3'd0,
    TGT_BOOT     = 3'd1,
    TGT_CART     = 3'd2,
    TGT_IO       = 3'd3,
    TGT_BLOCKED  = 3'd4
  } target_e;

  // where the read data of a result comes from
  typedef enum logic [2:0] {
    SRC_CONST = 3'd0,
    SRC_VRAM  = 3'd1,
    SRC_WRAM  = 3'd2,
    SRC_OAM   = 3'd3,
    SRC_HRAM  = 3'd4
  } src_e;

  // configuration register indexes
  localparam logic CFG_COLOR_MODE  = 1'b0;
  localparam logic CFG_BOOT_IN_USE = 1'b1;

  localparam logic MODE_WRITE = 1'b1;

  // address map
  localparam logic [15:0] ADDR_ROM_END    = 16'h7FFF;
  localparam logic [15:0] ADDR_VRAM_END   = 16'h9FFF;
  localparam logic [15:0] ADDR_EXT_END    = 16'hBFFF;
  localparam logic [15:0] ADDR_WRAM_END   = 16'hFDFF;
  localparam logic [15:0] ADDR_OAM_END    = 16'hFE9F;
  localparam logic [15:0] ADDR_UNUSED_END = 16'hFEFF;
  localparam logic [15:0] ADDR_IO_END     = 16'hFF7F;
  localparam logic [15:0] ADDR_HRAM_BASE  = 16'hFF80;
  localparam logic [15:0] ADDR_HRAM_END   = 16'hFFFE;
  localparam logic [15:0] ADDR_IE         = 16'hFFFF;
  localparam logic [15:0] ADDR_DMA        = 16'hFF46;
  localparam logic [15:0] ADDR_BOOT_OFF   = 16'hFF50;
  localparam logic [15:0] BOOT_LO_END     = 16'h0100;
  localparam logic [15:0] BOOT_EXT_BASE   = 16'h0200;
  localparam logic [15:0] BOOT_EXT_END    = 16'h0900;

  localparam int unsigned OAM_DEPTH  = 160;
  localparam int unsigned HRAM_DEPTH = 127;

  typedef struct packed {
    logic       mode;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        dma_active;
    logic [1:0]  ppu_mode;
    logic        vram_bank_select;
    logic [2:0]  wram_bank_select;
  } req_t;

  typedef struct packed {
    target_e     target;
    logic [15:0] forward_address;
    src_e        region;      // memory touched by the access
    src_e        src;         // read data source of the result
    logic [7:0]  const_data;
    logic        boot_off_we;
  } dec_t;

endpackage

// ===== src/bmmd_ram.sv =====
`timescale 1ns / 1ps

module bmmd_ram #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [7:0]               wdata_i,
  output logic [7:0]               rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/bmmd_decode.sv =====
`timescale 1ns / 1ps

module bmmd_decode #(
  parameter int unsigned WRAM_BANKS = 8,
  parameter int unsigned VRAM_BANKS = 2
) (
  input  bmmd_pkg::req_t                                req_i,
  input  logic                                          color_mode_i,
  input  logic                                          boot_rom_in_use_i,
  input  logic [7:0]                                    boot_rom_off_i,
  output bmmd_pkg::dec_t                                dec_o,
  output logic [13+$clog2(VRAM_BANKS)-1:0]              vram_addr_o,
  output logic [12+$clog2(WRAM_BANKS)-1:0]              wram_addr_o
);

  import bmmd_pkg::*;

  localparam int unsigned VA_W = 13 + $clog2(VRAM_BANKS);
  localparam int unsigned WB_W = $clog2(WRAM_BANKS);
  localparam int unsigned WA_W = 12 + WB_W;

  logic [15:0]     a;
  logic            wr;
  logic            blocked;
  logic            overlay;
  logic [WB_W-1:0] wsel_mod;
  logic [WB_W-1:0] wbank;
  logic            vbank;

  assign a  = req_i.address;
  assign wr = (req_i.mode == MODE_WRITE);

  assign blocked = req_i.dma_active && (a < ADDR_HRAM_BASE || a > ADDR_HRAM_END)
                   && (a != ADDR_DMA);

  assign overlay = boot_rom_in_use_i && (boot_rom_off_i == 8'h00)
                   && ((a < BOOT_LO_END)
                       || (color_mode_i && a >= BOOT_EXT_BASE && a < BOOT_EXT_END));

  // bank select reduced modulo the bank count, small lookup
  always_comb begin
    wsel_mod = '0;
    for (int i = 0; i < 8; i++) begin
      if (req_i.wram_bank_select == 3'(i)) begin
        wsel_mod = WB_W'(i % WRAM_BANKS);
      end
    end
  end

  always_comb begin
    if (color_mode_i && a[12]) begin
      wbank = (wsel_mod == '0) ? WB_W'(1) : wsel_mod;
    end else begin
      wbank = WB_W'(a[12]);
    end
  end

  assign vbank       = color_mode_i && req_i.vram_bank_select;
  // with one bank the cast drops the bank bit
  assign vram_addr_o = VA_W'({vbank, a[12:0]});
  assign wram_addr_o = WA_W'({wbank, a[11:0]});

  always_comb begin
    dec_o                 = '0;
    dec_o.target          = TGT_INTERNAL;
    dec_o.region          = SRC_CONST;
    dec_o.src             = SRC_CONST;
    priority if (blocked) begin
      dec_o.target     = TGT_BLOCKED;
      dec_o.const_data = wr ? 8'h00 : 8'hFF;
    end else if (a <= ADDR_ROM_END) begin
      dec_o.target          = (!wr && overlay) ? TGT_BOOT : TGT_CART;
      dec_o.forward_address = a;
    end else if (a <= ADDR_VRAM_END) begin
      dec_o.region = SRC_VRAM;
    end else if (a <= ADDR_EXT_END) begin
      dec_o.target          = TGT_CART;
      dec_o.forward_address = a;
    end else if (a <= ADDR_WRAM_END) begin
      dec_o.region = SRC_WRAM;
    end else if (a <= ADDR_OAM_END) begin
      dec_o.region = SRC_OAM;
    end else if (a <= ADDR_UNUSED_END) begin
      // ppu modes 2 and 3 read all ones
      dec_o.const_data = (!wr && req_i.ppu_mode[1]) ? 8'hFF : 8'h00;
    end else if (a == ADDR_BOOT_OFF) begin
      if (wr) begin
        dec_o.boot_off_we = (boot_rom_off_i == 8'h00);
      end else begin
        dec_o.const_data = boot_rom_off_i;
      end
    end else if (a <= ADDR_IO_END || a == ADDR_IE) begin
      dec_o.target          = TGT_IO;
      dec_o.forward_address = a;
    end else begin
      dec_o.region = SRC_HRAM;
    end
    dec_o.src = wr ? SRC_CONST : dec_o.region;
  end

endmodule

// ===== src/banked_memory_map_decoder.sv =====
`timescale 1ns / 1ps

// Memory map decoder for a banked handheld-console CPU bus. Each input item is
// one bus access; each yields exactly one result item. Video RAM
// (VRAM_BANKS x 8 KiB), work RAM (WRAM_BANKS x 4 KiB, echo mirrored up to
// 0xFDFF), the 160-byte sprite table and 127-byte high RAM live in on-chip
// synchronous RAMs; the boot-ROM-disable register at 0xFF50 takes writes only while
// it is still zero. Cartridge, boot ROM and I/O accesses come back with a target
// code and the forwarded address. Throughput is one item per clock while the
// output is not stalled: an access is decoded and its RAM read or write issued
// at the edge that accepts it, and the result is held in the output register
// (with the RAM read port's data register) from the next cycle. The input is only
// stalled while a result waits and the downstream side is not ready. RAM
// contents are undefined after reset and there is no clearing pass; read a
// location only after writing it. Configuration writes must be made while the
// block is idle.
module banked_memory_map_decoder #(
  parameter int unsigned WRAM_BANKS = 8,  // 2..8
  parameter int unsigned VRAM_BANKS = 2   // 1..2
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic        cfg_data_i,

  // access items in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // address[15:0], write_data[23:16], dma_active[24], ppu_mode[26:25],
  // vram_bank_select[27], wram_bank_select[30:28], zero[31]
  input  logic [31:0] s_axis_tdata,
  // mode[0]
  input  logic [0:0]  s_axis_tuser,

  // result items out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data[7:0], forward_address[23:8]
  output logic [23:0] m_axis_tdata,
  // target[2:0]
  output logic [2:0]  m_axis_tuser
);

  import bmmd_pkg::*;

  localparam int unsigned VRAM_DEPTH = VRAM_BANKS * 8192;
  localparam int unsigned WRAM_DEPTH = WRAM_BANKS * 4096;
  localparam int unsigned VA_W       = $clog2(VRAM_DEPTH);
  localparam int unsigned WA_W       = $clog2(WRAM_DEPTH);
  localparam int unsigned OA_W       = $clog2(OAM_DEPTH);
  localparam int unsigned HA_W       = $clog2(HRAM_DEPTH);

  // configuration and boot disable register
  logic       color_mode_q, color_mode_d;
  logic       boot_in_use_q, boot_in_use_d;
  logic [7:0] boot_off_q, boot_off_d;

  req_t            req;
  dec_t            dec;
  logic [VA_W-1:0] vram_addr;
  logic [WA_W-1:0] wram_addr;
  logic            accept;
  logic            rd_go;
  logic            wr_go;

  // result register
  logic        out_valid_q, out_valid_d;
  target_e     target_q, target_d;
  logic [15:0] fwd_q, fwd_d;
  src_e        src_q, src_d;
  logic [7:0]  const_q, const_d;

  logic [7:0] vram_rdata, wram_rdata, oam_rdata, hram_rdata;
  logic [7:0] read_data;

  assign req.mode             = s_axis_tuser[0];
  assign req.address          = s_axis_tdata[15:0];
  assign req.write_data       = s_axis_tdata[23:16];
  assign req.dma_active       = s_axis_tdata[24];
  assign req.ppu_mode         = s_axis_tdata[26:25];
  assign req.vram_bank_select = s_axis_tdata[27];
  assign req.wram_bank_select = s_axis_tdata[30:28];

  // a new item enters whenever the result slot is free or being emptied
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign rd_go         = accept && (req.mode != MODE_WRITE);
  assign wr_go         = accept && (req.mode == MODE_WRITE);

  bmmd_decode #(
    .WRAM_BANKS (WRAM_BANKS),
    .VRAM_BANKS (VRAM_BANKS)
  ) u_decode (
    .req_i             (req),
    .color_mode_i      (color_mode_q),
    .boot_rom_in_use_i (boot_in_use_q),
    .boot_rom_off_i    (boot_off_q),
    .dec_o             (dec),
    .vram_addr_o       (vram_addr),
    .wram_addr_o       (wram_addr)
  );

  // memories: written or read at the accepting edge only, so read data
  // stays put while the result is stalled
  bmmd_ram #(.DEPTH(VRAM_DEPTH)) u_vram (
    .clk_i   (clk_i),
    .we_i    (wr_go && dec.region == SRC_VRAM),
    .re_i    (rd_go && dec.region == SRC_VRAM),
    .addr_i  (vram_addr),
    .wdata_i (req.write_data),
    .rdata_o (vram_rdata)
  );

  bmmd_ram #(.DEPTH(WRAM_DEPTH)) u_wram (
    .clk_i   (clk_i),
    .we_i    (wr_go && dec.region == SRC_WRAM),
    .re_i    (rd_go && dec.region == SRC_WRAM),
    .addr_i  (wram_addr),
    .wdata_i (req.write_data),
    .rdata_o (wram_rdata)
  );

  // sprite table offset from 0xFE00 is the low byte
  bmmd_ram #(.DEPTH(OAM_DEPTH)) u_oam (
    .clk_i   (clk_i),
    .we_i    (wr_go && dec.region == SRC_OAM),
    .re_i    (rd_go && dec.region == SRC_OAM),
    .addr_i  (req.address[OA_W-1:0]),
    .wdata_i (req.write_data),
    .rdata_o (oam_rdata)
  );

  // high ram offset from 0xFF80 is the low seven bits
  bmmd_ram #(.DEPTH(HRAM_DEPTH)) u_hram (
    .clk_i   (clk_i),
    .we_i    (wr_go && dec.region == SRC_HRAM),
    .re_i    (rd_go && dec.region == SRC_HRAM),
    .addr_i  (req.address[HA_W-1:0]),
    .wdata_i (req.write_data),
    .rdata_o (hram_rdata)
  );

  always_comb begin
    color_mode_d  = color_mode_q;
    boot_in_use_d = boot_in_use_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_COLOR_MODE:  color_mode_d  = cfg_data_i;
        CFG_BOOT_IN_USE: boot_in_use_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // one-shot: decode only asserts the write while the register is still zero
  assign boot_off_d = (wr_go && dec.boot_off_we) ? req.write_data : boot_off_q;

  always_comb begin
    out_valid_d = out_valid_q;
    target_d    = target_q;
    fwd_d       = fwd_q;
    src_d       = src_q;
    const_d     = const_q;
    if (accept) begin
      out_valid_d = 1'b1;
      target_d    = dec.target;
      fwd_d       = dec.forward_address;
      src_d       = dec.src;
      const_d     = dec.const_data;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q  <= 1'b0;
      boot_in_use_q <= 1'b1;
      boot_off_q    <= 8'h00;
      out_valid_q   <= 1'b0;
    end else begin
      color_mode_q  <= color_mode_d;
      boot_in_use_q <= boot_in_use_d;
      boot_off_q    <= boot_off_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    target_q <= target_d;
    fwd_q    <= fwd_d;
    src_q    <= src_d;
    const_q  <= const_d;
  end

  // pick the registered ram data or the decoded constant
  always_comb begin
    unique case (src_q)
      SRC_VRAM: read_data = vram_rdata;
      SRC_WRAM: read_data = wram_rdata;
      SRC_OAM:  read_data = oam_rdata;
      SRC_HRAM: read_data = hram_rdata;
      default:  read_data = const_q;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {fwd_q, read_data};
  assign m_axis_tuser  = target_q;

endmodule
